FILE: rtl/lesf_pkg.sv
// Shared types and constants for the largest empty square finder.
// No dependencies; all other files but lesf_line_buf take names from here by scope.
`default_nettype none

package lesf_pkg;

    localparam int MAX_COLS_DEF = 1024;
    localparam int MAX_ROWS_DEF = 1024;

    localparam int CHAR_W  = 8;
    localparam int WIDTH_W = 11;
    localparam int SIZE_W  = 11;
    localparam int POS_W   = 10;

    localparam int APB_DW = 32;
    localparam int APB_AW = 3;

    localparam int RES_DEPTH = 4;
    localparam int RES_AW    = 2;
    localparam int RES_CW    = 3;

    localparam logic REG_OBSTACLE = 1'b0;
    localparam logic REG_ROW_WIDTH = 1'b1;

    localparam logic [CHAR_W-1:0]  OBSTACLE_RESET  = 8'd111;
    localparam logic [WIDTH_W-1:0] ROW_WIDTH_RESET = 11'd1024;

    typedef struct packed {
        logic [CHAR_W-1:0]  obstacle_char;
        logic [WIDTH_W-1:0] row_width;
    } cfg_t;

    typedef struct packed {
        logic              rows_overflow;
        logic [POS_W-1:0]  left_col;
        logic [POS_W-1:0]  top_row;
        logic [SIZE_W-1:0] square_size;
    } res_t;

endpackage

`default_nettype wire

FILE: rtl/lesf_cfg.sv
// APB register file: obstacle character and row width.
// Depends on lesf_pkg.
`default_nettype none

module lesf_cfg
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [lesf_pkg::APB_AW-1:0] paddr,
    input  wire logic [lesf_pkg::APB_DW-1:0] pwdata,
    output logic      [lesf_pkg::APB_DW-1:0] prdata,
    output logic                            pready,
    output lesf_pkg::cfg_t                  cfg
);

    lesf_pkg::cfg_t cfg_reg;
    lesf_pkg::cfg_t cfg_next;
    logic           wr_en;
    logic           reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_sel = paddr[2];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_sel)
                lesf_pkg::REG_OBSTACLE:
                    cfg_next.obstacle_char = pwdata[lesf_pkg::CHAR_W-1:0];
                lesf_pkg::REG_ROW_WIDTH:
                    cfg_next.row_width = pwdata[lesf_pkg::WIDTH_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.obstacle_char <= lesf_pkg::OBSTACLE_RESET;
            cfg_reg.row_width     <= lesf_pkg::ROW_WIDTH_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (reg_sel)
            lesf_pkg::REG_OBSTACLE:
                prdata = lesf_pkg::APB_DW'(cfg_reg.obstacle_char);
            lesf_pkg::REG_ROW_WIDTH:
                prdata = lesf_pkg::APB_DW'(cfg_reg.row_width);
            default:
                prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

FILE: rtl/lesf_line_buf.sv
// Line buffer: one write port, one read port with registered read data.
// Holds the previous row's square sizes. No dependencies.
`default_nettype none

module lesf_line_buf
#(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 11
)
(
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [DW-1:0] wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [DW-1:0] rd_data
);

    logic [DW-1:0] mem_reg [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: rtl/lesf_core.sv
// Scan pipeline: position tracking, line buffer read-modify-write with
// forwarding, best-square tracking. Depends on lesf_pkg, lesf_line_buf.
`default_nettype none

module lesf_core
#(
    parameter int MAX_COLS = lesf_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = lesf_pkg::MAX_ROWS_DEF
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  lesf_pkg::cfg_t                  cfg,
    input  wire logic                       fire,
    input  wire logic [lesf_pkg::CHAR_W-1:0] cell_char,
    input  wire logic                       last_cell,
    output logic                            res_push,
    output lesf_pkg::res_t                  res_data
);

    localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RW  = $clog2(MAX_ROWS + 1);
    localparam int RIW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int EW  = (CW + 1 > lesf_pkg::WIDTH_W) ? CW + 1 : lesf_pkg::WIDTH_W;
    localparam int SW  = lesf_pkg::SIZE_W;
    localparam int TW  = ((RIW > SW) ? RIW : SW) + 1;
    localparam int LW  = ((CW > SW) ? CW : SW) + 1;

    localparam logic [EW-1:0] MAX_COLS_E = EW'(MAX_COLS);
    localparam logic [RW-1:0] MAX_ROWS_R = RW'(MAX_ROWS);

    // position stage
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [EW-1:0] eff_width;
    logic          wrap;
    logic          row_ovf;

    // compute stage
    logic          s1_vld_reg;
    logic          s1_last_reg;
    logic          s1_ovf_reg;
    logic          s1_blocked_reg;
    logic          s1_border_reg;
    logic [CW-1:0] s1_col_reg;
    logic [RIW-1:0] s1_row_reg;

    logic [SW-1:0] left_reg, left_next;
    logic [SW-1:0] diag_reg, diag_next;
    logic [SW-1:0] peak_size_reg, peak_size_next;
    logic [RIW-1:0] peak_row_reg, peak_row_next;
    logic [CW-1:0] peak_col_reg, peak_col_next;
    logic          ovf_seen_reg, ovf_seen_next;

    logic          fwd_vld_reg;
    logic [CW-1:0] fwd_addr_reg;
    logic [SW-1:0] fwd_val_reg;

    logic [SW-1:0] rd_data;
    logic [SW-1:0] up;
    logic [SW-1:0] min_ul;
    logic [SW-1:0] min_all;
    logic [SW-1:0] cell_size;
    logic          upd;
    logic [SW-1:0] size_new;
    logic [RIW-1:0] row_new;
    logic [CW-1:0] col_new;
    logic          ovf_new;

    // result stage
    logic          s2_vld_reg;
    logic [SW-1:0] s2_size_reg;
    logic [RIW-1:0] s2_row_reg;
    logic [CW-1:0] s2_col_reg;
    logic          s2_ovf_reg;
    logic [TW-1:0] top_full;
    logic [LW-1:0] left_full;

    always_comb
    begin
        if (cfg.row_width == '0 || EW'(cfg.row_width) > MAX_COLS_E)
        begin
            eff_width = MAX_COLS_E;
        end
        else
        begin
            eff_width = EW'(cfg.row_width);
        end
        wrap    = (EW'(col_reg) + EW'(1)) >= eff_width;
        row_ovf = row_reg >= MAX_ROWS_R;

        col_next = col_reg;
        row_next = row_reg;
        if (fire)
        begin
            if (last_cell)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (wrap)
            begin
                col_next = '0;
                if (!row_ovf)
                begin
                    row_next = row_reg + RW'(1);
                end
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg    <= '0;
            row_reg    <= '0;
            s1_vld_reg <= 1'b0;
        end
        else
        begin
            col_reg    <= col_next;
            row_reg    <= row_next;
            s1_vld_reg <= fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            s1_last_reg    <= last_cell;
            s1_ovf_reg     <= row_ovf;
            s1_blocked_reg <= (cell_char == cfg.obstacle_char);
            s1_border_reg  <= (row_reg == '0) || (col_reg == '0);
            s1_col_reg     <= col_reg;
            s1_row_reg     <= row_reg[RIW-1:0];
        end
    end

    lesf_line_buf
    #(
        .DEPTH (MAX_COLS),
        .AW    (CW),
        .DW    (SW)
    )
    u_line_buf
    (
        .clk     (clk),
        .wr_en   (upd),
        .wr_addr (s1_col_reg),
        .wr_data (cell_size),
        .rd_en   (fire),
        .rd_addr (col_reg),
        .rd_data (rd_data)
    );

    always_comb
    begin
        if (fwd_vld_reg && fwd_addr_reg == s1_col_reg)
        begin
            up = fwd_val_reg;
        end
        else
        begin
            up = rd_data;
        end
        min_ul  = (up < left_reg) ? up : left_reg;
        min_all = (min_ul < diag_reg) ? min_ul : diag_reg;
        if (s1_blocked_reg)
        begin
            cell_size = '0;
        end
        else if (s1_border_reg)
        begin
            cell_size = SW'(1);
        end
        else
        begin
            cell_size = min_all + SW'(1);
        end

        upd = s1_vld_reg & ~s1_ovf_reg;
        if (upd && cell_size > peak_size_reg)
        begin
            size_new = cell_size;
            row_new  = s1_row_reg;
            col_new  = s1_col_reg;
        end
        else
        begin
            size_new = peak_size_reg;
            row_new  = peak_row_reg;
            col_new  = peak_col_reg;
        end
        ovf_new = ovf_seen_reg | (s1_vld_reg & s1_ovf_reg);

        left_next      = upd ? cell_size : left_reg;
        diag_next      = upd ? up : diag_reg;
        peak_size_next = size_new;
        peak_row_next  = row_new;
        peak_col_next  = col_new;
        ovf_seen_next  = ovf_new;
        if (s1_vld_reg && s1_last_reg)
        begin
            left_next      = '0;
            diag_next      = '0;
            peak_size_next = '0;
            peak_row_next  = '0;
            peak_col_next  = '0;
            ovf_seen_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg      <= '0;
            diag_reg      <= '0;
            peak_size_reg <= '0;
            peak_row_reg  <= '0;
            peak_col_reg  <= '0;
            ovf_seen_reg  <= 1'b0;
            fwd_vld_reg   <= 1'b0;
            s2_vld_reg    <= 1'b0;
        end
        else
        begin
            left_reg      <= left_next;
            diag_reg      <= diag_next;
            peak_size_reg <= peak_size_next;
            peak_row_reg  <= peak_row_next;
            peak_col_reg  <= peak_col_next;
            ovf_seen_reg  <= ovf_seen_next;
            fwd_vld_reg   <= fwd_vld_reg | upd;
            s2_vld_reg    <= s1_vld_reg & s1_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (upd)
        begin
            fwd_addr_reg <= s1_col_reg;
            fwd_val_reg  <= cell_size;
        end
        s2_size_reg <= size_new;
        s2_row_reg  <= row_new;
        s2_col_reg  <= col_new;
        s2_ovf_reg  <= ovf_new;
    end

    assign top_full  = TW'(s2_row_reg) + TW'(1) - TW'(s2_size_reg);
    assign left_full = LW'(s2_col_reg) + LW'(1) - LW'(s2_size_reg);

    always_comb
    begin
        res_data.square_size   = s2_size_reg;
        res_data.rows_overflow = s2_ovf_reg;
        if (s2_size_reg == '0)
        begin
            res_data.top_row  = '0;
            res_data.left_col = '0;
        end
        else
        begin
            res_data.top_row  = top_full[lesf_pkg::POS_W-1:0];
            res_data.left_col = left_full[lesf_pkg::POS_W-1:0];
        end
    end

    assign res_push = s2_vld_reg;

endmodule

`default_nettype wire

FILE: rtl/lesf_res_fifo.sv
// Result queue with slot reservation at input acceptance.
// Depends on lesf_pkg.
`default_nettype none

module lesf_res_fifo
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     reserve,
    output logic          room,
    input  wire logic     push,
    input  lesf_pkg::res_t push_data,
    output logic          m_tvalid,
    input  wire logic     m_tready,
    output lesf_pkg::res_t m_tdata
);

    localparam int AW = lesf_pkg::RES_AW;
    localparam int CW = lesf_pkg::RES_CW;

    lesf_pkg::res_t entry_reg [lesf_pkg::RES_DEPTH];
    logic [AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [CW-1:0]  pend_reg, pend_next;
    logic           pop;

    assign m_tvalid = (cnt_reg != '0);
    assign m_tdata  = entry_reg[rd_ptr_reg];
    assign pop      = m_tvalid & m_tready;
    assign room     = (pend_reg < CW'(lesf_pkg::RES_DEPTH));

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + AW'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + CW'(push) - CW'(pop);
        pend_next   = pend_reg + CW'(reserve) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
            pend_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
            pend_reg   <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/largest_empty_square_finder.sv
// Largest empty square finder, top level.
// Depends on lesf_pkg, lesf_cfg, lesf_core, lesf_res_fifo.
//
// Usage:
//   Cells enter on the s_ stream in raster order, one per transaction:
//   s_tdata carries the cell character, s_tlast marks the final cell of a map.
//   A cell equal to the obstacle character is blocked. One result per map
//   leaves on the m_ stream once the final cell has passed the compute
//   and result stages into the result queue: side of the first strictly
//   largest empty square, its top-left row and column, and a flag for maps
//   taller than MAX_ROWS. Throughput is one cell per cycle while s_tready is
//   high; the line buffer is read in the cycle before its write-back, and a
//   forwarding register covers consecutive cells that hit the same entry.
//   The APB port holds the obstacle character (offset 0x0) and the row width
//   (offset 0x4); write them only while no map is in flight.
//   Reset clears position, best-square state and the result queue; the line
//   buffer is not cleared and needs no clearing pass.
//   Up to four results may wait for the receiver; while four maps have ended
//   and are not yet taken, s_tready drops and cell input stalls.
`default_nettype none

module largest_empty_square_finder
#(
    parameter int MAX_COLS = lesf_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = lesf_pkg::MAX_ROWS_DEF
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [lesf_pkg::CHAR_W-1:0] s_tdata,   // [7:0] cell_char
    input  wire logic                        s_tlast,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    // [10:0] square_size, [20:11] top_row, [30:21] left_col, [31] rows_overflow
    output logic [31:0]                      m_tdata,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [lesf_pkg::APB_AW-1:0] paddr,
    input  wire logic [lesf_pkg::APB_DW-1:0] pwdata,
    output logic      [lesf_pkg::APB_DW-1:0] prdata,
    output logic                             pready
);

    lesf_pkg::cfg_t cfg;
    lesf_pkg::res_t res_data;
    lesf_pkg::res_t head;
    logic           res_push;
    logic           room;
    logic           fire;

    assign s_tready = room;
    assign fire     = s_tvalid & s_tready;
    assign m_tdata  = head;

    lesf_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lesf_core
    #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    )
    u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .fire      (fire),
        .cell_char (s_tdata),
        .last_cell (s_tlast),
        .res_push  (res_push),
        .res_data  (res_data)
    );

    lesf_res_fifo u_res_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .reserve   (fire & s_tlast),
        .room      (room),
        .push      (res_push),
        .push_data (res_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (head)
    );

endmodule

`default_nettype wire

FILE: rtl/lesf_checker.sv
// Port-level checks for the largest empty square finder, bound to the top.
// Depends on lesf_pkg.
`default_nettype none

module lesf_checker
(
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        s_tvalid,
    input wire logic                        s_tready,
    input wire logic                        s_tlast,
    input wire logic                        m_tvalid,
    input wire logic                        m_tready,
    input wire logic [31:0]                 m_tdata
);

    localparam int CW = lesf_pkg::RES_CW;

    logic [CW-1:0] pend_reg;
    logic          in_last;
    logic          out_take;

    assign in_last  = s_tvalid & s_tready & s_tlast;
    assign out_take = m_tvalid & m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_reg + CW'(in_last) - CW'(out_take);
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed or dropped while stalled");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> pend_reg != '0)
        else $error("result shown without a finished map");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg >= CW'(lesf_pkg::RES_DEPTH) |-> !s_tready)
        else $error("cells accepted with result queue full");

    a_empty_origin: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[10:0] == '0 |-> m_tdata[30:11] == '0)
        else $error("empty result carries a nonzero corner");

endmodule

bind largest_empty_square_finder lesf_checker u_lesf_checker (.*);

`default_nettype wire

FILE: tb/tb.sv
// Testbench for largest_empty_square_finder: streams grid maps in raster order and
// checks every per-map square result against an in-bench scoring model.
// Depends on lesf_pkg and the largest_empty_square_finder RTL only.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CHAR_W     = lesf_pkg::CHAR_W;
    localparam int          WIDTH_W    = lesf_pkg::WIDTH_W;
    localparam int          SIZE_W     = lesf_pkg::SIZE_W;
    localparam int          POS_W      = lesf_pkg::POS_W;
    localparam int          APB_AW     = lesf_pkg::APB_AW;
    localparam int          APB_DW     = lesf_pkg::APB_DW;
    localparam int          MAX_COLS   = lesf_pkg::MAX_COLS_DEF;
    localparam int          MAX_ROWS   = lesf_pkg::MAX_ROWS_DEF;
    localparam int unsigned RANDOM_CELLS = 240;
    localparam int unsigned RANDOM_MAPS  = 10;
    localparam int unsigned REPORT_LIMIT = 10;
    localparam time         LIMIT_NS   = 5_000_000;

    localparam logic [APB_AW-1:0] ADDR_OBSTACLE  = {lesf_pkg::REG_OBSTACLE, 2'b00};
    localparam logic [APB_AW-1:0] ADDR_ROW_WIDTH = {lesf_pkg::REG_ROW_WIDTH, 2'b00};

    typedef struct packed {
        logic [CHAR_W-1:0] glyph;
        logic              closes_map;
    } map_cell_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [CHAR_W-1:0]    s_tdata;   // [7:0] cell_char
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    // [10:0] square_size, [20:11] top_row, [30:21] left_col, [31] rows_overflow
    logic [31:0]          m_tdata;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [APB_AW-1:0]    paddr;
    logic [APB_DW-1:0]    pwdata;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;

    map_cell_t       pending_cells[$];
    lesf_pkg::res_t  pending_squares[$];

    logic [CHAR_W-1:0]  obstacle_code;
    logic [WIDTH_W-1:0] width_setting;
    logic [POS_W-1:0]   map_col;
    logic [WIDTH_W-1:0] map_row;
    logic [SIZE_W-1:0]  left_run;
    logic [SIZE_W-1:0]  diag_run;
    logic [SIZE_W-1:0]  line_sizes [MAX_COLS];
    logic [SIZE_W-1:0]  top_side;
    logic [POS_W-1:0]   top_end_row;
    logic [POS_W-1:0]   top_end_col;
    logic               rows_exceeded;

    logic        cell_taken;
    int unsigned burst_left;
    int unsigned idle_gap;
    logic        stall_now;
    int unsigned stall_count;

    int unsigned cells_accepted;
    int unsigned squares_checked;
    int unsigned maps_queued;
    int unsigned settings_written;
    int unsigned error_count;

    largest_empty_square_finder dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic restart_map();
        map_col       = '0;
        map_row       = '0;
        left_run      = '0;
        diag_run      = '0;
        top_side      = '0;
        top_end_row   = '0;
        top_end_col   = '0;
        rows_exceeded = 1'b0;
    endtask

    // Score one cell of the current map; on the closing cell, queue the square.
    task automatic score_cell(input logic [CHAR_W-1:0] glyph, input logic closes_map);
        int unsigned        span;
        logic [SIZE_W-1:0]  up;
        logic [SIZE_W-1:0]  side;
        lesf_pkg::res_t     square;
        span = (width_setting == 0 || width_setting > MAX_COLS) ? MAX_COLS : width_setting;
        if (map_row >= MAX_ROWS)
        begin
            rows_exceeded = 1'b1;
        end
        else
        begin
            up = line_sizes[map_col];
            if (glyph == obstacle_code)
                side = '0;
            else if (map_row == 0 || map_col == 0)
                side = 1;
            else
            begin
                side = up;
                if (left_run < side)
                    side = left_run;
                if (diag_run < side)
                    side = diag_run;
                side = side + 1'b1;
            end
            diag_run = up;
            left_run = side;
            line_sizes[map_col] = side;
            if (side > top_side)
            begin
                top_side    = side;
                top_end_row = map_row[POS_W-1:0];
                top_end_col = map_col;
            end
        end
        if (int'(map_col) + 1 >= int'(span))
        begin
            map_col = '0;
            if (map_row < MAX_ROWS)
                map_row = map_row + 1'b1;
        end
        else
        begin
            map_col = map_col + 1'b1;
        end
        if (closes_map)
        begin
            square.square_size   = top_side;
            square.top_row       = '0;
            square.left_col      = '0;
            if (top_side != 0)
            begin
                square.top_row  = POS_W'(int'(top_end_row) + 1 - int'(top_side));
                square.left_col = POS_W'(int'(top_end_col) + 1 - int'(top_side));
            end
            square.rows_overflow = rows_exceeded;
            pending_squares.push_back(square);
            restart_map();
        end
    endtask

    always @(posedge clk)
    begin : observer
        lesf_pkg::res_t got;
        lesf_pkg::res_t want;
        cell_taken = 1'b0;
        if (rst_n)
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr)
                    ADDR_OBSTACLE:  obstacle_code = pwdata[CHAR_W-1:0];
                    ADDR_ROW_WIDTH: width_setting = pwdata[WIDTH_W-1:0];
                    default:        ;
                endcase
            end
            if (m_tvalid && m_tready)
            begin
                got = lesf_pkg::res_t'(m_tdata);
                if (pending_squares.size() == 0)
                begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                        $display("%0t: unexpected result size=%0d top=%0d left=%0d ovf=%0b",
                                 $time, got.square_size, got.top_row, got.left_col,
                                 got.rows_overflow);
                end
                else
                begin
                    want = pending_squares.pop_front();
                    squares_checked++;
                    if (got !== want)
                    begin
                        error_count++;
                        if (error_count <= REPORT_LIMIT)
                            $display({"%0t: result mismatch: expected size=%0d top=%0d ",
                                      "left=%0d ovf=%0b, got size=%0d top=%0d left=%0d ovf=%0b"},
                                     $time, want.square_size, want.top_row, want.left_col,
                                     want.rows_overflow, got.square_size, got.top_row,
                                     got.left_col, got.rows_overflow);
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                cell_taken = 1'b1;
                cells_accepted++;
                score_cell(s_tdata, s_tlast);
            end
        end
    end

    always @(negedge clk)
    begin : cell_driver
        map_cell_t item;
        logic      next_valid;
        if (rst_n && (!s_tvalid || cell_taken))
        begin
            next_valid = 1'b0;
            if (idle_gap > 0)
            begin
                idle_gap--;
            end
            else if (pending_cells.size() > 0)
            begin
                item = pending_cells.pop_front();
                s_tdata    <= item.glyph;
                s_tlast    <= item.closes_map;
                next_valid = 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 40);
                    idle_gap   = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
                end
                else
                begin
                    burst_left--;
                end
            end
            s_tvalid <= next_valid;
        end
    end

    always @(negedge clk)
    begin : result_sink
        if (rst_n)
        begin
            if (stall_count > 0)
            begin
                stall_count--;
            end
            else
            begin
                stall_now   = !stall_now;
                stall_count = stall_now ? $urandom_range(1, 12)
                                        : (($urandom_range(4) == 0) ? 80 : $urandom_range(1, 30));
            end
            m_tready <= !stall_now;
        end
    end

    task automatic push_cell(input logic [CHAR_W-1:0] glyph, input logic closes_map);
        pending_cells.push_back('{glyph: glyph, closes_map: closes_map});
        if (closes_map)
            maps_queued++;
    endtask

    task automatic queue_map(input int unsigned n, input int unsigned density,
                             input logic [CHAR_W-1:0] blocked);
        logic [CHAR_W-1:0] c;
        for (int unsigned i = 0; i < n; i++)
        begin
            if ($urandom_range(99) < density)
                c = blocked;
            else
            begin
                c = CHAR_W'($urandom_range(255));
                if (c == blocked)
                    c = ~c;
            end
            push_cell(c, i == n - 1);
        end
    endtask

    task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        settings_written++;
    endtask

    // Drain all cells and results, then let the pipeline go quiet.
    task automatic settle();
        while (pending_cells.size() != 0 || s_tvalid || pending_squares.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    initial
    begin : stimulus
        int unsigned       random_cells;
        int unsigned       random_maps;
        int unsigned       span;
        int unsigned       n;
        int unsigned       rows;
        logic [CHAR_W-1:0] blocked;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        m_tready = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        cell_taken  = 1'b0;
        burst_left  = 1;
        idle_gap    = 0;
        stall_now   = 1'b1;
        stall_count = 0;
        cells_accepted   = 0;
        squares_checked  = 0;
        maps_queued      = 0;
        settings_written = 0;
        error_count      = 0;
        random_cells     = 0;
        random_maps      = 0;
        obstacle_code = lesf_pkg::OBSTACLE_RESET;
        width_setting = lesf_pkg::ROW_WIDTH_RESET;
        foreach (line_sizes[i])
            line_sizes[i] = '0;
        restart_map();

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        push_cell(8'd46, 1'b1);
        push_cell(lesf_pkg::OBSTACLE_RESET, 1'b1);
        settle();

        apb_write(ADDR_ROW_WIDTH, APB_DW'(3));
        apb_write(ADDR_OBSTACLE, APB_DW'(8'h00));
        for (int i = 0; i < 9; i++)
            push_cell(8'hFF, i == 8);
        settle();

        apb_write(ADDR_ROW_WIDTH, APB_DW'(4));
        apb_write(ADDR_OBSTACLE, APB_DW'(8'hFF));
        push_cell(8'h00, 1'b0);
        push_cell(8'hFF, 1'b0);
        push_cell(8'h00, 1'b0);
        push_cell(8'h00, 1'b0);
        for (int i = 0; i < 4; i++)
            push_cell(8'h00, i == 3);
        settle();

        while (random_cells < RANDOM_CELLS || random_maps < RANDOM_MAPS)
        begin
            case ($urandom_range(5))
                0:       blocked = 8'h00;
                1:       blocked = 8'hFF;
                default: blocked = CHAR_W'($urandom_range(255));
            endcase
            case ($urandom_range(7))
                0:       span = 1;
                1:       span = 2;
                default: span = $urandom_range(3, 12);
            endcase
            apb_write(ADDR_OBSTACLE, APB_DW'(blocked));
            apb_write(ADDR_ROW_WIDTH, APB_DW'(span));
            repeat ($urandom_range(3, 6))
            begin
                if ($urandom_range(4) == 0)
                    n = $urandom_range(1, 3);
                else
                begin
                    rows = $urandom_range(1, 10);
                    n = rows * span + ($urandom_range(1) ? $urandom_range(0, span - 1) : 0);
                end
                queue_map(n, $urandom_range(0, 40), blocked);
                random_cells += n;
                random_maps++;
            end
            settle();
        end

        for (int k = 0; k < 3; k++)
        begin
            blocked = CHAR_W'($urandom_range(255));
            case (k)
                0:       span = 0;
                1:       span = MAX_COLS;
                default: span = $urandom_range(MAX_COLS + 1, 2047);
            endcase
            apb_write(ADDR_OBSTACLE, APB_DW'(blocked));
            apb_write(ADDR_ROW_WIDTH, APB_DW'(span));
            queue_map($urandom_range(20, 60), $urandom_range(10, 40), blocked);
            settle();
        end

        blocked = CHAR_W'($urandom_range(255));
        apb_write(ADDR_OBSTACLE, APB_DW'(blocked));
        apb_write(ADDR_ROW_WIDTH, APB_DW'(1));
        queue_map(MAX_ROWS + $urandom_range(1, 6), 30, blocked);
        settle();

        repeat (20) @(posedge clk);
        $display("Checked %0d results from %0d maps (%0d cells) across %0d register writes,",
                 squares_checked, maps_queued, cells_accepted, settings_written);
        $display("with narrow and out-of-range row widths, obstacle codes 0 and 255, and a map past %0d rows.",
                 MAX_ROWS);
        if (error_count == 0 && pending_squares.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin : watchdog
        #(LIMIT_NS);
        $display("TEST FAILED");
        $finish;
    end

endmodule
